/* rtl/quaternion_to_euler_rpy_top_assert.svh */
// Assertion macros used by the checker file of this block.
// All of them sample on clk_i and are off while rst_ni is low.
`ifndef QUATERNION_TO_EULER_RPY_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_RPY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Q2E_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("q2e assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("q2e assertion failed");

`endif

/* rtl/q2e_pkg.sv */
`timescale 1ns / 1ps

package q2e_pkg;

  // Defaults for the top level parameters.
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fixed datapath widths.
  localparam int FIELD_W    = 16;  // port fields
  localparam int PROD_W     = 32;  // Q1.15 * Q1.15 products
  localparam int SUM_W      = 34;  // doubled product sums in Q30
  localparam int SIN_W      = 32;  // clamped asin argument
  localparam int SQ_W       = 64;  // square of the asin argument
  localparam int SQRT_W     = 62;  // remainder and root of the square root
  localparam int SQRT_STEPS = 31;  // one result bit per cell
  localparam int CW         = 36;  // CORDIC x and y
  localparam int ZW         = 32;  // CORDIC angle, a full turn is 2^32
  localparam int PITCH_LIM  = 16384;

  // Lane order inside the CORDIC row.
  localparam int LANES      = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [SUM_W-1:0] Q_ONE    = 34'sd1073741824;
  localparam logic [SQ_W-1:0]         Q_ONE_SQ = 64'd1 << 60;
  localparam logic [ZW-1:0]           ANG_QUARTER       = 32'h4000_0000;
  localparam logic [ZW-1:0]           ANG_THREE_QUARTER = 32'hC000_0000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quat_w;
    logic signed [FIELD_W-1:0] quat_x;
    logic signed [FIELD_W-1:0] quat_y;
    logic signed [FIELD_W-1:0] quat_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] yaw_angle;
  } euler_out_t;

  // Square root cell contents, with the atan2 operands riding along.
  typedef struct packed {
    logic [SQRT_W-1:0]        rem;
    logic [SQRT_W-1:0]        root;
    logic signed [SUM_W-1:0]  rn;
    logic signed [SUM_W-1:0]  rd;
    logic signed [SUM_W-1:0]  yn;
    logic signed [SUM_W-1:0]  yd;
    logic signed [SIN_W-1:0]  s;
  } sqrt_data_t;

  // One CORDIC lane; zero marks an atan2 of two zero operands.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 zero;
  } cordic_lane_t;

  // atan(2^-i) scaled so that a full turn is 2^32.
  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/q2e_sqrt_cell.sv */
`timescale 1ns / 1ps

module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  q2e_pkg::sqrt_data_t   data_i,
  output logic                  valid_o,
  output q2e_pkg::sqrt_data_t   data_o
);
  import q2e_pkg::*;

  // Weight of the result bit that this cell decides.
  localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

  logic [SQRT_W-1:0] trial;
  sqrt_data_t        data_d, data_q;
  logic              valid_q;

  // One restoring step of the digit-by-digit square root.
  always_comb begin
    data_d = data_i;
    trial  = data_i.root + BIT;
    if (data_i.rem >= trial) begin
      data_d.rem  = data_i.rem - trial;
      data_d.root = (data_i.root >> 1) + BIT;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/q2e_cordic_cell.sv */
`timescale 1ns / 1ps

module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  q2e_pkg::cordic_lane_t [q2e_pkg::LANES-1:0] lane_i,
  output logic                                      valid_o,
  output q2e_pkg::cordic_lane_t [q2e_pkg::LANES-1:0] lane_o
);
  import q2e_pkg::*;

  localparam logic [ZW-1:0] ANGLE = atan_entry(5'(STAGE));

  cordic_lane_t [LANES-1:0] lane_d, lane_q;
  logic signed [CW-1:0]     xs [LANES];
  logic signed [CW-1:0]     ys [LANES];
  logic                     valid_q;

  // One vectoring micro-rotation per lane, driving y toward zero.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      xs[k]     = lane_i[k].x;
      ys[k]     = lane_i[k].y;
      lane_d[k] = lane_i[k];
      if (!ys[k][CW-1]) begin
        lane_d[k].x = xs[k] + (ys[k] >>> STAGE);
        lane_d[k].y = ys[k] - (xs[k] >>> STAGE);
        lane_d[k].z = lane_i[k].z + ANGLE;
      end else begin
        lane_d[k].x = xs[k] - (ys[k] >>> STAGE);
        lane_d[k].y = ys[k] + (xs[k] >>> STAGE);
        lane_d[k].z = lane_i[k].z - ANGLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

/* rtl/quaternion_to_euler_rpy_top.sv */
`timescale 1ns / 1ps

// Quaternion to ZYX Euler angles. One unit quaternion (w, x, y, z, signed Q1.15) is taken
// per transaction and roll, pitch and yaw come back as signed binary angles (32768 = pi),
// rounded to ANGLE_WIDTH bits; pitch is saturated at plus or minus a quarter turn. The
// block takes a new quaternion every cycle while in_stall_o is low, and each one passes in turn
// through three front registers (products, sums, radicand), 31 square root cells,
// one quadrant pre-rotation, one CORDIC cell per stage for all three angles, and the
// output register. When the output is stalled the pipeline keeps moving until a result
// reaches its last cell, so bubbles are squeezed out before the input is stalled.
module quaternion_to_euler_rpy_top #(
  parameter int ANGLE_WIDTH   = q2e_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  q2e_pkg::quat_in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output q2e_pkg::euler_out_t out_data_o
);
  import q2e_pkg::*;

  localparam logic signed [ANGLE_WIDTH-1:0] PLIM = ANGLE_WIDTH'(1) <<< (ANGLE_WIDTH - 2);
  localparam logic signed [ANGLE_WIDTH-1:0] NLIM = -PLIM;

  // Quadrant pre-rotation so the CORDIC starts in the right half plane.
  function automatic cordic_lane_t pre_rot(input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
    cordic_lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x    = x;
    l.y    = y;
    l.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = ANG_QUARTER;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = ANG_THREE_QUARTER;
      end
    end
    return l;
  endfunction

  logic en;
  logic last_valid;
  logic out_load;

  // Front stage registers.
  logic                     p_valid_q, s_valid_q, q_valid_q;
  logic signed [PROD_W-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q;
  logic signed [PROD_W-1:0] p_wy_q, p_zx_q;
  logic signed [SUM_W-1:0]  rn_d, rd_d, yn_d, yd_d, s_full;
  logic signed [SUM_W-1:0]  rn_q, rd_q, yn_q, yd_q;
  logic signed [SIN_W-1:0]  s_d, s_q;
  logic signed [SQ_W-1:0]   ss;
  sqrt_data_t               sq_in_d, sq_in_q;

  // Cell rows.
  sqrt_data_t               sq_data  [SQRT_STEPS+1];
  logic                     sq_valid [SQRT_STEPS+1];
  cordic_lane_t [LANES-1:0] cd_lane  [CORDIC_STAGES+1];
  logic                     cd_valid [CORDIC_STAGES+1];
  cordic_lane_t [LANES-1:0] pre_d, pre_q;
  logic                     pre_valid_q;

  // Output stage.
  logic signed [ANGLE_WIDTH-1:0] ang [LANES];
  logic signed [ANGLE_WIDTH-1:0] pitch_c;
  euler_out_t                    out_d, out_q;
  logic                          out_valid_q;

  // The whole pipeline holds only when a result is blocked at its end.
  assign last_valid = cd_valid[CORDIC_STAGES];
  assign en         = !(out_valid_q && out_stall_i && last_valid);
  assign in_stall_o = !en;
  assign out_load   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      s_valid_q   <= 1'b0;
      q_valid_q   <= 1'b0;
      pre_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        p_valid_q   <= in_valid_i;
        s_valid_q   <= p_valid_q;
        q_valid_q   <= s_valid_q;
        pre_valid_q <= sq_valid[SQRT_STEPS];
      end
      if (out_load) begin
        out_valid_q <= last_valid;
      end
    end
  end

  // Doubled product sums in Q30, with the asin argument clamped to one.
  always_comb begin
    rn_d   = (SUM_W'(p_wx_q) + SUM_W'(p_yz_q)) <<< 1;
    rd_d   = Q_ONE - ((SUM_W'(p_xx_q) + SUM_W'(p_yy_q)) <<< 1);
    yn_d   = (SUM_W'(p_wz_q) + SUM_W'(p_xy_q)) <<< 1;
    yd_d   = Q_ONE - ((SUM_W'(p_yy_q) + SUM_W'(p_zz_q)) <<< 1);
    s_full = (SUM_W'(p_wy_q) - SUM_W'(p_zx_q)) <<< 1;
    if (s_full > Q_ONE) begin
      s_d = SIN_W'(Q_ONE);
    end else if (s_full < -Q_ONE) begin
      s_d = SIN_W'(-Q_ONE);
    end else begin
      s_d = SIN_W'(s_full);
    end
  end

  // Radicand of the cosine of pitch: one minus the square of the sine.
  always_comb begin
    ss           = SQ_W'(s_q) * SQ_W'(s_q);
    sq_in_d.rem  = SQRT_W'(Q_ONE_SQ - SQ_W'(ss));
    sq_in_d.root = '0;
    sq_in_d.rn   = rn_q;
    sq_in_d.rd   = rd_q;
    sq_in_d.yn   = yn_q;
    sq_in_d.yd   = yd_q;
    sq_in_d.s    = s_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q  <= PROD_W'(in_data_i.quat_w) * PROD_W'(in_data_i.quat_x);
      p_yz_q  <= PROD_W'(in_data_i.quat_y) * PROD_W'(in_data_i.quat_z);
      p_xx_q  <= PROD_W'(in_data_i.quat_x) * PROD_W'(in_data_i.quat_x);
      p_yy_q  <= PROD_W'(in_data_i.quat_y) * PROD_W'(in_data_i.quat_y);
      p_wz_q  <= PROD_W'(in_data_i.quat_w) * PROD_W'(in_data_i.quat_z);
      p_xy_q  <= PROD_W'(in_data_i.quat_x) * PROD_W'(in_data_i.quat_y);
      p_zz_q  <= PROD_W'(in_data_i.quat_z) * PROD_W'(in_data_i.quat_z);
      p_wy_q  <= PROD_W'(in_data_i.quat_w) * PROD_W'(in_data_i.quat_y);
      p_zx_q  <= PROD_W'(in_data_i.quat_z) * PROD_W'(in_data_i.quat_x);
      rn_q    <= rn_d;
      rd_q    <= rd_d;
      yn_q    <= yn_d;
      yd_q    <= yd_d;
      s_q     <= s_d;
      sq_in_q <= sq_in_d;
      pre_q   <= pre_d;
    end
  end

  // Square root row, one result bit per cell.
  assign sq_data[0]  = sq_in_q;
  assign sq_valid[0] = q_valid_q;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    q2e_sqrt_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // Pre-rotation of the three atan2 operand pairs.
  always_comb begin
    pre_d[LANE_ROLL]  = pre_rot(CW'(sq_data[SQRT_STEPS].rn), CW'(sq_data[SQRT_STEPS].rd));
    pre_d[LANE_PITCH] = pre_rot(CW'(sq_data[SQRT_STEPS].s), CW'(sq_data[SQRT_STEPS].root));
    pre_d[LANE_YAW]   = pre_rot(CW'(sq_data[SQRT_STEPS].yn), CW'(sq_data[SQRT_STEPS].yd));
  end

  // CORDIC row, one micro-rotation per cell for all three angles.
  assign cd_lane[0]  = pre_q;
  assign cd_valid[0] = pre_valid_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cd_valid[i]),
      .lane_i  (cd_lane[i]),
      .valid_o (cd_valid[i+1]),
      .lane_o  (cd_lane[i+1])
    );
  end

  // Round each angle half up to ANGLE_WIDTH bits.
  for (genvar k = 0; k < LANES; k++) begin : g_ang
    logic [ZW-1:0] zf;
    assign zf = cd_lane[CORDIC_STAGES][k].zero ? '0 : cd_lane[CORDIC_STAGES][k].z;
    if (ANGLE_WIDTH < ZW) begin : g_rnd
      logic [ZW-1:0] r;
      assign r      = zf + (ZW'(1) << (ZW - ANGLE_WIDTH - 1));
      assign ang[k] = r[ZW-1 -: ANGLE_WIDTH];
    end else begin : g_full
      assign ang[k] = zf[ANGLE_WIDTH-1:0];
    end
  end

  // Saturate pitch at a quarter turn and size the fields for the port.
  always_comb begin
    if (ang[LANE_PITCH] > PLIM) begin
      pitch_c = PLIM;
    end else if (ang[LANE_PITCH] < NLIM) begin
      pitch_c = NLIM;
    end else begin
      pitch_c = ang[LANE_PITCH];
    end
    out_d.roll_angle  = FIELD_W'(ang[LANE_ROLL]);
    out_d.pitch_angle = FIELD_W'(pitch_c);
    out_d.yaw_angle   = FIELD_W'(ang[LANE_YAW]);
  end

  always_ff @(posedge clk_i) begin
    if (out_load && last_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/q2e_checker.sv */
`timescale 1ns / 1ps
`include "quaternion_to_euler_rpy_top_assert.svh"

module q2e_checker #(
  parameter int ANGLE_WIDTH = q2e_pkg::ANGLE_WIDTH_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input q2e_pkg::euler_out_t out_data_o
);
  import q2e_pkg::*;

  // The input is held back only while a result is blocked at the output.
  `Q2E_ASSERT_SAME(a_stall_cause, in_valid_i && in_stall_o, out_valid_o && out_stall_i)

  // Pitch never leaves a quarter turn when the field carries the whole angle.
  `Q2E_ASSERT_SAME(a_pitch_range, out_valid_o,
                   (ANGLE_WIDTH > FIELD_W) || ((out_data_o.pitch_angle >= -PITCH_LIM) &&
                   (out_data_o.pitch_angle <= PITCH_LIM)))

  // A stalled result stays offered and unchanged.
  `Q2E_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind quaternion_to_euler_rpy_top q2e_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_q2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
